[design/first_fit_segment_allocator_defines.svh]
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define FFSA_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FFSA_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/ffsa_pkg.sv]
// shared constants and codes of the first-fit segment allocator
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ADDR_BITS_DEF    = 16;

    localparam int ARENA_BITS  = 17;
    localparam int FIELD_BITS  = 16;
    localparam int NEED_BITS   = 17;

    localparam logic [ARENA_BITS-1:0] ARENA_RESET = 17'h10000;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FIT    = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

endpackage

[design/ffsa_seg_ram.sv]
// segment table memory: one write port, one registered read port
module ffsa_seg_ram #(
    parameter int DEPTH = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/first_fit_segment_allocator.sv]
// first-fit segment allocator: top level with walk/scan sequencer over the segment table
//
// input beat (s_*): s_tuser is the request kind (0 allocate, 1 free), s_tdata carries
// the requested byte count and the payload offset to free. every beat gives exactly one
// result beat (m_*): a status code and the payload offset of an allocated segment.
// cfg_* writes the arena size; the table then restarts as one free segment.
// an allocate follows the links from the head, one table entry per cycle through the
// registered read port of the table memory: it is accepted, walks the list (a last walk
// step sees the end of the list when nothing fits), writes the remainder in a split step
// when the segment is split, and then loads the output. a free scans entries 0 upward
// one per cycle and reports an unknown address once past the last entry. one request
// is in work at a time. after reset, and after each cfg write, the init state rewrites
// table entry 0 while no beat is taken; only that entry is written, the fill count hides
// the rest. the result sits in an output register: a stalled receiver holds it there
// while the next request is already accepted and worked on; only loading the next
// result waits.
`include "first_fit_segment_allocator_defines.svh"

module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] req_size, [31:16] free_addr
    input  logic        s_tuser,   // [0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [17:2] payload_addr, [23:18] zero
    // arena size register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int LW   = $clog2(MAX_SEGMENTS + 1);
    localparam int AB   = ADDR_BITS;
    localparam int SZW  = (ADDR_BITS < ffsa_pkg::ARENA_BITS) ? ADDR_BITS
                                                             : ffsa_pkg::ARENA_BITS;
    localparam int CW   = (ADDR_BITS > ffsa_pkg::FIELD_BITS) ? ADDR_BITS
                                                             : ffsa_pkg::FIELD_BITS;
    localparam int NW   = ffsa_pkg::NEED_BITS;
    localparam int EW   = AB + SZW + 1 + LW;
    localparam logic [ffsa_pkg::ARENA_BITS:0] ARENA_CAP =
        (ADDR_BITS >= ffsa_pkg::ARENA_BITS) ? (ffsa_pkg::ARENA_BITS+1)'(18'h1FFFF)
                                            : (ffsa_pkg::ARENA_BITS+1)'(64'd1 << ADDR_BITS);
    localparam logic [LW-1:0] SEG_NULL = LW'(MAX_SEGMENTS);

    typedef struct packed {
        logic [AB-1:0]  start;
        logic [SZW-1:0] size;
        logic           free;
        logic [LW-1:0]  next;
    } seg_entry_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_SCAN,
        ST_SPLIT,
        ST_RESP
    } state_t;

    state_t                         state_reg, state_next;
    logic [ffsa_pkg::ARENA_BITS-1:0] arena_reg, arena_next;
    logic [LW-1:0]                  count_reg, count_next;
    logic [LW-1:0]                  cur_reg, cur_next;
    logic [LW-1:0]                  step_reg, step_next;
    logic [ffsa_pkg::FIELD_BITS-1:0] req_reg, req_next;
    logic [ffsa_pkg::FIELD_BITS-1:0] faddr_reg, faddr_next;
    seg_entry_t                     pend_reg, pend_next;
    logic [IW-1:0]                  pend_idx_reg, pend_idx_next;
    ffsa_pkg::status_t              res_status_reg, res_status_next;
    logic [ffsa_pkg::FIELD_BITS-1:0] res_addr_reg, res_addr_next;
    logic                           m_valid_reg, m_valid_next;
    ffsa_pkg::status_t              m_status_reg, m_status_next;
    logic [ffsa_pkg::FIELD_BITS-1:0] m_addr_reg, m_addr_next;

    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [EW-1:0]     rd_raw;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    seg_entry_t        wr_entry;
    seg_entry_t        ent;

    logic [ffsa_pkg::ARENA_BITS:0] arena_clamped;
    logic [SZW-1:0]    init_size;
    logic [NW-1:0]     need;
    logic [NW-1:0]     rem;
    logic              fits;
    logic              split_ok;
    logic [AB-1:0]     ent_payload;
    logic [LW-1:0]     cur_inc;
    logic              s_accept;
    logic              cfg_accept;

    ffsa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW),
        .AW    (IW)
    ) u_seg_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    assign ent = seg_entry_t'(rd_raw);

    // reinit size: arena clamped to the address space, less one header
    always_comb begin
        arena_clamped = {1'b0, arena_reg};
        if (arena_clamped > ARENA_CAP) begin
            arena_clamped = ARENA_CAP;
        end
        if (arena_clamped > (ffsa_pkg::ARENA_BITS+1)'(HEADER_BYTES)) begin
            init_size = SZW'(arena_clamped - (ffsa_pkg::ARENA_BITS+1)'(HEADER_BYTES));
        end else begin
            init_size = '0;
        end
    end

    assign need        = NW'(req_reg) + NW'(HEADER_BYTES);
    assign rem         = NW'(ent.size) - NW'(req_reg);
    assign fits        = ent.free && (NW'(ent.size) >= need);
    assign split_ok    = (rem > NW'(HEADER_BYTES)) && (count_reg < SEG_NULL);
    assign ent_payload = ent.start + AB'(HEADER_BYTES);
    assign cur_inc     = cur_reg + LW'(1);

    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        arena_next      = arena_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        req_next        = req_reg;
        faddr_next      = faddr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_entry        = ent;

        unique case (state_reg)
            ST_INIT: begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_entry.start = '0;
                wr_entry.size  = init_size;
                wr_entry.free  = 1'b1;
                wr_entry.next  = SEG_NULL;
                count_next     = LW'(1);
                state_next     = ST_IDLE;
            end
            ST_IDLE: begin
                if (cfg_accept) begin
                    arena_next = cfg_data;
                    state_next = ST_INIT;
                end else if (s_accept) begin
                    req_next   = s_tdata[15:0];
                    faddr_next = s_tdata[31:16];
                    cur_next   = '0;
                    step_next  = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = (ffsa_pkg::req_kind_t'(s_tuser) == ffsa_pkg::REQ_FREE)
                                 ? ST_SCAN : ST_WALK;
                end
            end
            ST_WALK: begin
                if (!(cur_reg < count_reg) || !(step_reg < SEG_NULL)) begin
                    res_status_next = ffsa_pkg::STATUS_NO_FIT;
                    res_addr_next   = '0;
                    state_next      = ST_RESP;
                end else if (fits) begin
                    res_status_next = ffsa_pkg::STATUS_OK;
                    res_addr_next   = ffsa_pkg::FIELD_BITS'(ent_payload);
                    wr_en           = 1'b1;
                    wr_addr         = cur_reg[IW-1:0];
                    wr_entry.free   = 1'b0;
                    if (split_ok) begin
                        // shrink this segment and link the remainder in behind it
                        wr_entry.size   = SZW'(req_reg);
                        wr_entry.next   = count_reg;
                        pend_next.start = ent.start + AB'(need);
                        pend_next.size  = SZW'(rem - NW'(HEADER_BYTES));
                        pend_next.free  = 1'b1;
                        pend_next.next  = ent.next;
                        pend_idx_next   = count_reg[IW-1:0];
                        count_next      = count_reg + LW'(1);
                        state_next      = ST_SPLIT;
                    end else begin
                        state_next = ST_RESP;
                    end
                end else begin
                    cur_next  = ent.next;
                    step_next = step_reg + LW'(1);
                    rd_en     = 1'b1;
                    rd_addr   = ent.next[IW-1:0];
                end
            end
            ST_SPLIT: begin
                wr_en      = 1'b1;
                wr_addr    = pend_idx_reg;
                wr_entry   = pend_reg;
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                res_addr_next = '0;
                if (!(cur_reg < count_reg)) begin
                    res_status_next = ffsa_pkg::STATUS_NOT_FOUND;
                    state_next      = ST_RESP;
                end else if (CW'(ent_payload) == CW'(faddr_reg)) begin
                    res_status_next = ffsa_pkg::STATUS_OK;
                    wr_en           = 1'b1;
                    wr_addr         = cur_reg[IW-1:0];
                    wr_entry.free   = 1'b1;
                    state_next      = ST_RESP;
                end else begin
                    cur_next = cur_inc;
                    rd_en    = 1'b1;
                    rd_addr  = cur_inc[IW-1:0];
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            arena_reg   <= ffsa_pkg::ARENA_RESET;
            count_reg   <= LW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            arena_reg   <= arena_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        req_reg        <= req_next;
        faddr_reg      <= faddr_next;
        pend_reg       <= pend_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_addr_reg, m_status_reg};

    `FFSA_ASSERT(a_count_bound, aclk, aresetn, 1'b1, count_reg <= SEG_NULL, "segment count overflow")
    `FFSA_ASSERT(a_err_addr_zero, aclk, aresetn, m_valid_reg && (m_status_reg != ffsa_pkg::STATUS_OK), m_addr_reg == '0, "error result with nonzero address")
    `FFSA_ASSERT(a_no_write_idle, aclk, aresetn, (state_reg == ST_IDLE) || (state_reg == ST_RESP), !wr_en, "table write outside a request")
    `FFSA_ASSERT_NEXT(a_split_follow, aclk, aresetn, state_reg == ST_SPLIT, (state_reg == ST_RESP) && (count_reg == $past(count_reg)), "split write-back out of order")

endmodule
